// ----- sv/gale_pkg.sv -----
// Shared types and codes for the guest ALU / load-store execute core.
`timescale 1ns / 1ps

package gale_pkg;

    // Operation codes
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_OR   = 4'd2;
    localparam logic [3:0] OP_BEXT = 4'd3;
    localparam logic [3:0] OP_CLZ  = 4'd4;
    localparam logic [3:0] OP_SLTI = 4'd5;
    localparam logic [3:0] OP_SSAT = 4'd6;
    localparam logic [3:0] OP_USAT = 4'd7;
    localparam logic [3:0] OP_LD   = 4'd8;
    localparam logic [3:0] OP_ST   = 4'd9;
    localparam logic [3:0] OP_LDP  = 4'd10;

    // Completion status codes
    localparam logic [1:0] STATUS_DONE       = 2'd0;
    localparam logic [1:0] STATUS_MISALIGNED = 2'd1;
    localparam logic [1:0] STATUS_RANGE      = 2'd2;

    typedef struct packed {
        logic [3:0]         op;
        logic [4:0]         dest_reg;
        logic [4:0]         dest_reg_2;
        logic [4:0]         src_reg_a;
        logic [4:0]         src_reg_b;
        logic signed [15:0] immediate;
    } gale_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_value;
        logic [31:0] result_value_2;
    } gale_out_t;

    // Register file write-back: first and second destination
    typedef struct packed {
        logic        we1;
        logic        we2;
        logic [31:0] v1;
        logic [31:0] v2;
    } rf_wb_t;

    // Data memory access issued from the execute stage
    typedef struct packed {
        logic        wr;
        logic        rd_pair;
        logic [29:0] word;
        logic [31:0] wdata;
    } dmem_cmd_t;

endpackage

// ----- sv/guest_alu_load_store_execute_core.sv -----
// Top level: three-stage guest execute pipeline over register file and data memory.
//
//  Channel  Dir  Handshake                     Beat
//  instr    in   instr_valid / instr_ready     gale_in_t: one instruction
//  result   out  result_valid / result_ready   gale_out_t: status and written words
//
// One instruction per cycle sustained while results are taken and no memory clear runs; each
// accepted instruction passes the execute, memory/write-back and output register stages in turn.
// Rate is set by the execute stage: operand forwarding, address add and
// bounds compare feed the data memory banks in the same cycle.
// After reset the data memory is swept clear row by row over ceil(MEM_WORDS/2) rows with instr_ready low;
// the register file clears at once.
// A stalled output backs up stage by stage; up to three instructions are held in flight.
`timescale 1ns / 1ps

module guest_alu_load_store_execute_core import gale_pkg::*; #(
    parameter int NUM_REGS  = 32,
    parameter int MEM_WORDS = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      instr_valid,
    output logic      instr_ready,
    input  gale_in_t  instr,
    output logic      result_valid,
    input  logic      result_ready,
    output gale_out_t result
);

    localparam int RW = $clog2(NUM_REGS);
    localparam logic [29:0] LAST_WORD = 30'(MEM_WORDS - 1);
    localparam logic [29:0] LAST_PAIR = 30'(MEM_WORDS - 2);

    function automatic logic [RW-1:0] wrap_reg(input logic [4:0] f);
        logic [8:0] v;
        v = {4'b0000, f};
        for (int k = 0; k < 4; k++)
        begin
            if (v >= 9'(NUM_REGS))
            begin
                v = v - 9'(NUM_REGS);
            end
        end
        return v[RW-1:0];
    endfunction

    // pipeline control
    logic s1_v_reg, s1_v_next;
    logic s2_v_reg, s2_v_next;
    logic out_v_reg, out_v_next;
    logic out_free, s2_free, s1_free, s2_adv, s1_adv, accept;
    logic dm_busy;

    // execute stage
    logic [3:0]         s1_op_reg, s1_op_next;
    logic signed [15:0] s1_imm_reg, s1_imm_next;
    logic [RW-1:0]      s1_ra_reg, s1_ra_next;
    logic [RW-1:0]      s1_rb_reg, s1_rb_next;
    logic [RW-1:0]      s1_rd_reg, s1_rd_next;
    logic [RW-1:0]      s1_rd2_reg, s1_rd2_next;

    // memory / write-back stage
    logic [1:0]    s2_status_reg, s2_status_next;
    logic [31:0]   s2_alu_reg, s2_alu_next;
    logic [RW-1:0] s2_rd_reg, s2_rd_next;
    logic [RW-1:0] s2_rd2_reg, s2_rd2_next;
    logic          s2_we1_reg, s2_we1_next;
    logic          s2_we2_reg, s2_we2_next;
    logic          s2_load_reg, s2_load_next;

    // last write into the register file
    rf_wb_t        wb_reg, wb_next;
    logic [RW-1:0] wb_rd_reg, wb_rd2_reg;

    gale_out_t out_reg, out_next;

    logic [31:0] rf_a, rf_b, op_a, op_b, alu_value, addr;
    logic [31:0] s2_v1, s2_v2, dm_word0, dm_word1;
    logic        is_ld, is_st, is_ldp, is_mem, misal, oor, mem_ok, alu_op;
    logic [1:0]  ex_status;
    rf_wb_t      rf_wr;
    dmem_cmd_t   dm_cmd;

    assign out_free    = !out_v_reg || result_ready;
    assign s2_adv      = s2_v_reg && out_free;
    assign s2_free     = !s2_v_reg || out_free;
    assign s1_adv      = s1_v_reg && s2_free;
    assign s1_free     = !s1_v_reg || s2_free;
    assign instr_ready = s1_free && !dm_busy;
    assign accept      = instr_valid && instr_ready;

    // operand read: re-read the held indices while the execute stage stalls
    assign s1_ra_next  = s1_free ? wrap_reg(instr.src_reg_a) : s1_ra_reg;
    assign s1_rb_next  = s1_free ? wrap_reg(instr.src_reg_b) : s1_rb_reg;
    assign s1_rd_next  = s1_free ? wrap_reg(instr.dest_reg) : s1_rd_reg;
    assign s1_rd2_next = s1_free ? wrap_reg(instr.dest_reg_2) : s1_rd2_reg;
    assign s1_op_next  = s1_free ? instr.op : s1_op_reg;
    assign s1_imm_next = s1_free ? instr.immediate : s1_imm_reg;

    gale_regfile #(.NUM_REGS(NUM_REGS)) u_regfile (
        .clk(clk), .rst_n(rst_n),
        .ra(s1_ra_next), .rb(s1_rb_next),
        .rd1(s2_rd_reg), .rd2(s2_rd2_reg), .wr(rf_wr),
        .rdata_a(rf_a), .rdata_b(rf_b)
    );

    // newest value wins: stage 2, then the write at the last edge, then the file
    function automatic logic [31:0] fwd(input logic [RW-1:0] idx, input logic [31:0] ram_val);
        logic [31:0] v;
        v = ram_val;
        if (wb_reg.we1 && wb_rd_reg == idx)
            v = wb_reg.v1;
        if (wb_reg.we2 && wb_rd2_reg == idx)
            v = wb_reg.v2;
        if (s2_v_reg && s2_we1_reg && s2_rd_reg == idx)
            v = s2_v1;
        if (s2_v_reg && s2_we2_reg && s2_rd2_reg == idx)
            v = s2_v2;
        return v;
    endfunction

    always_comb
    begin
        op_a = fwd(s1_ra_reg, rf_a);
        op_b = fwd(s1_rb_reg, rf_b);
    end

    gale_alu u_alu (
        .op(s1_op_reg), .a(op_a), .b(op_b), .immediate(s1_imm_reg), .value(alu_value)
    );

    assign addr   = op_a + {{16{s1_imm_reg[15]}}, s1_imm_reg};
    assign is_ld  = (s1_op_reg == OP_LD);
    assign is_st  = (s1_op_reg == OP_ST);
    assign is_ldp = (s1_op_reg == OP_LDP);
    assign is_mem = is_ld || is_st || is_ldp;
    assign alu_op = s1_op_reg inside {[OP_ADD:OP_USAT]};
    assign misal  = (addr[1:0] != 2'b00);
    assign oor    = is_ldp ? (addr[31:2] > LAST_PAIR) : (addr[31:2] > LAST_WORD);
    assign mem_ok = is_mem && !misal && !oor;

    always_comb
    begin
        if (!is_mem)
            ex_status = STATUS_DONE;
        else if (misal)
            ex_status = STATUS_MISALIGNED;
        else if (oor)
            ex_status = STATUS_RANGE;
        else
            ex_status = STATUS_DONE;
    end

    assign dm_cmd.wr      = mem_ok && is_st;
    assign dm_cmd.rd_pair = is_ldp;
    assign dm_cmd.word    = addr[31:2];
    assign dm_cmd.wdata   = op_b;

    gale_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
        .clk(clk), .rst_n(rst_n), .issue(s1_adv), .cmd(dm_cmd),
        .busy(dm_busy), .word0(dm_word0), .word1(dm_word1)
    );

    assign s2_status_next = s2_free ? ex_status : s2_status_reg;
    assign s2_alu_next    = s2_free ? alu_value : s2_alu_reg;
    assign s2_rd_next     = s2_free ? s1_rd_reg : s2_rd_reg;
    assign s2_rd2_next    = s2_free ? s1_rd2_reg : s2_rd2_reg;
    assign s2_we1_next    = s2_free ? (alu_op || (mem_ok && (is_ld || is_ldp))) : s2_we1_reg;
    assign s2_we2_next    = s2_free ? (mem_ok && is_ldp) : s2_we2_reg;
    assign s2_load_next   = s2_free ? (mem_ok && (is_ld || is_ldp)) : s2_load_reg;

    assign s2_v1 = s2_load_reg ? dm_word0 : s2_alu_reg;
    assign s2_v2 = s2_we2_reg ? dm_word1 : 32'd0;

    assign rf_wr.we1 = s2_adv && s2_we1_reg;
    assign rf_wr.we2 = s2_adv && s2_we2_reg;
    assign rf_wr.v1  = s2_v1;
    assign rf_wr.v2  = s2_v2;
    assign wb_next   = rf_wr;

    always_comb
    begin
        out_next = out_reg;
        if (out_free)
        begin
            out_next.status         = s2_status_reg;
            out_next.result_value   = s2_v1;
            out_next.result_value_2 = s2_v2;
        end
    end

    assign s1_v_next  = s1_free ? accept : s1_v_reg;
    assign s2_v_next  = s2_free ? s1_v_reg : s2_v_reg;
    assign out_v_next = out_free ? s2_v_reg : out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            wb_reg    <= '0;
        end
        else
        begin
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s2_v_next;
            out_v_reg <= out_v_next;
            wb_reg    <= wb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg     <= s1_op_next;
        s1_imm_reg    <= s1_imm_next;
        s1_ra_reg     <= s1_ra_next;
        s1_rb_reg     <= s1_rb_next;
        s1_rd_reg     <= s1_rd_next;
        s1_rd2_reg    <= s1_rd2_next;
        s2_status_reg <= s2_status_next;
        s2_alu_reg    <= s2_alu_next;
        s2_rd_reg     <= s2_rd_next;
        s2_rd2_reg    <= s2_rd2_next;
        s2_we1_reg    <= s2_we1_next;
        s2_we2_reg    <= s2_we2_next;
        s2_load_reg   <= s2_load_next;
        wb_rd_reg     <= s2_rd_reg;
        wb_rd2_reg    <= s2_rd2_reg;
        out_reg       <= out_next;
    end

    assign result_valid = out_v_reg;
    assign result       = out_reg;

    // a faulting access never writes the register file
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_v_reg && s2_status_reg != STATUS_DONE) |-> (!s2_we1_reg && !s2_we2_reg))
        else $error("register write on faulted access");

    // second destination only from a load pair, which also writes the first
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_v_reg && s2_we2_reg) |-> (s2_we1_reg && s2_load_reg))
        else $error("second write without load pair");

    // nothing in flight while the data memory is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        dm_busy |-> (!s1_v_reg && !s2_v_reg && !out_v_reg))
        else $error("instruction in flight during memory clear");

    // a full, stalled pipeline takes no new beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !result_ready && s2_v_reg && s1_v_reg) |-> !instr_ready)
        else $error("accept into full stalled pipeline");

endmodule

// ----- sv/gale_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module gale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/gale_alu.sv -----
// Integer ALU: add, sub, or, bit extract, clz, slti and the two saturations.
`timescale 1ns / 1ps

module gale_alu import gale_pkg::*; (
    input  logic [3:0]         op,
    input  logic [31:0]        a,
    input  logic [31:0]        b,
    input  logic signed [15:0] immediate,
    output logic [31:0]        value
);

    // Each set mask bit lands at the count of mask bits below it.
    function automatic logic [31:0] bit_extract(input logic [31:0] src, input logic [31:0] mask);
        logic [31:0] res;
        logic [31:0] below;
        logic [5:0]  pos;
        res = '0;
        for (int i = 0; i < 32; i++)
        begin
            below = mask & ((32'd1 << i) - 32'd1);
            pos   = 6'($countones(below));
            if (mask[i] && src[i])
            begin
                res[pos[4:0]] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic [5:0] lead_zeros(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

    logic [31:0] imm_ext;
    logic [31:0] sat_hi;
    logic [31:0] sat_lo;
    logic [31:0] ssat_val;
    logic [31:0] usat_val;

    assign imm_ext = {{16{immediate[15]}}, immediate};
    assign sat_hi  = (32'd1 << immediate[4:0]) - 32'd1;
    assign sat_lo  = ~sat_hi;   // -(2^n)

    always_comb
    begin
        if ($signed(a) > $signed(sat_hi))
            ssat_val = sat_hi;
        else if ($signed(a) < $signed(sat_lo))
            ssat_val = sat_lo;
        else
            ssat_val = a;
        // clamps above only; negative values pass
        usat_val = ($signed(a) > $signed(sat_hi)) ? sat_hi : a;
    end

    always_comb
    begin
        case (op)
            OP_ADD:  value = a + b;
            OP_SUB:  value = a - b;
            OP_OR:   value = a | b;
            OP_BEXT: value = bit_extract(a, b);
            OP_CLZ:  value = {26'd0, lead_zeros(a)};
            OP_SLTI: value = ($signed(a) < $signed(imm_ext)) ? 32'd1 : 32'd0;
            OP_SSAT: value = ssat_val;
            OP_USAT: value = usat_val;
            default: value = 32'd0;
        endcase
    end

endmodule

// ----- sv/gale_regfile.sv -----
// Two-read, two-write register file: replicated RAM banks with a live-value table.
`timescale 1ns / 1ps

module gale_regfile import gale_pkg::*; #(
    parameter int NUM_REGS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [$clog2(NUM_REGS)-1:0] ra,
    input  logic [$clog2(NUM_REGS)-1:0] rb,
    input  logic [$clog2(NUM_REGS)-1:0] rd1,
    input  logic [$clog2(NUM_REGS)-1:0] rd2,
    input  rf_wb_t                      wr,
    output logic [31:0]                 rdata_a,
    output logic [31:0]                 rdata_b
);

    localparam int RW = $clog2(NUM_REGS);

    logic [NUM_REGS-1:0] vld_reg, vld_next;
    logic [NUM_REGS-1:0] lvt_reg, lvt_next;   // 1: latest value sits in bank 2
    logic [RW-1:0]       ra_q_reg, rb_q_reg;
    logic [31:0]         b1_a, b1_b, b2_a, b2_b;

    // bank 1 takes first-destination writes, bank 2 second-destination writes
    gale_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_b1_a (
        .clk(clk), .we(wr.we1), .waddr(rd1), .wdata(wr.v1), .raddr(ra), .rdata(b1_a)
    );
    gale_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_b1_b (
        .clk(clk), .we(wr.we1), .waddr(rd1), .wdata(wr.v1), .raddr(rb), .rdata(b1_b)
    );
    gale_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_b2_a (
        .clk(clk), .we(wr.we2), .waddr(rd2), .wdata(wr.v2), .raddr(ra), .rdata(b2_a)
    );
    gale_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_b2_b (
        .clk(clk), .we(wr.we2), .waddr(rd2), .wdata(wr.v2), .raddr(rb), .rdata(b2_b)
    );

    always_comb
    begin
        vld_next = vld_reg;
        lvt_next = lvt_reg;
        if (wr.we1)
        begin
            vld_next[rd1] = 1'b1;
            lvt_next[rd1] = 1'b0;
        end
        // second target wins when both name the same register
        if (wr.we2)
        begin
            vld_next[rd2] = 1'b1;
            lvt_next[rd2] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            lvt_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            lvt_reg <= lvt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_q_reg <= ra;
        rb_q_reg <= rb;
    end

    // Table state is current; a write at the last edge is covered by forwarding upstream.
    assign rdata_a = !vld_reg[ra_q_reg] ? 32'd0 : (lvt_reg[ra_q_reg] ? b2_a : b1_a);
    assign rdata_b = !vld_reg[rb_q_reg] ? 32'd0 : (lvt_reg[rb_q_reg] ? b2_b : b1_b);

endmodule

// ----- sv/gale_dmem.sv -----
// Word data memory in even/odd banks, so a load pair reads both words at once.
`timescale 1ns / 1ps

module gale_dmem import gale_pkg::*; #(
    parameter int MEM_WORDS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        issue,
    input  dmem_cmd_t   cmd,
    output logic        busy,
    output logic [31:0] word0,
    output logic [31:0] word1
);

    localparam int EVEN_DEPTH = (MEM_WORDS + 1) / 2;
    localparam int ODD_DEPTH  = MEM_WORDS / 2;
    localparam int EAW        = $clog2(EVEN_DEPTH);
    localparam int OAW        = $clog2(ODD_DEPTH);
    localparam logic [EAW-1:0] CLR_LAST = EAW'(EVEN_DEPTH - 1);
    localparam logic [EAW-1:0] ODD_LAST = EAW'(ODD_DEPTH - 1);

    logic           clr_busy_reg, clr_busy_next;
    logic [EAW-1:0] clr_row_reg, clr_row_next;
    logic [EAW-1:0] raddr_e_reg, raddr_e_next;
    logic [OAW-1:0] raddr_o_reg, raddr_o_next;
    logic           parity_reg, parity_next;

    logic [EAW-1:0] cmd_row_e;
    logic [OAW-1:0] cmd_row_o;
    logic           e_we, o_we;
    logic [EAW-1:0] e_waddr;
    logic [OAW-1:0] o_waddr;
    logic [31:0]    e_wdata, o_wdata;
    logic [31:0]    e_rdata, o_rdata;

    // an odd first word of a pair takes its partner from the next even row
    assign cmd_row_e = cmd.word[EAW:1] + EAW'(cmd.rd_pair & cmd.word[0]);
    assign cmd_row_o = cmd.word[OAW:1];

    // hold the read address while the downstream stage holds its data
    assign raddr_e_next = issue ? cmd_row_e : raddr_e_reg;
    assign raddr_o_next = issue ? cmd_row_o : raddr_o_reg;
    assign parity_next  = issue ? cmd.word[0] : parity_reg;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_row_next  = clr_row_reg;
        if (clr_busy_reg)
        begin
            clr_row_next = clr_row_reg + EAW'(1);
            if (clr_row_reg == CLR_LAST)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clr_busy_reg)
        begin
            e_we    = 1'b1;
            e_waddr = clr_row_reg;
            e_wdata = 32'd0;
            o_we    = (clr_row_reg <= ODD_LAST);
            o_waddr = clr_row_reg[OAW-1:0];
            o_wdata = 32'd0;
        end
        else
        begin
            e_we    = issue && cmd.wr && !cmd.word[0];
            e_waddr = cmd_row_e;
            e_wdata = cmd.wdata;
            o_we    = issue && cmd.wr && cmd.word[0];
            o_waddr = cmd_row_o;
            o_wdata = cmd.wdata;
        end
    end

    gale_ram #(.WIDTH(32), .DEPTH(EVEN_DEPTH)) u_even (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(raddr_e_next), .rdata(e_rdata)
    );
    gale_ram #(.WIDTH(32), .DEPTH(ODD_DEPTH)) u_odd (
        .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr(raddr_o_next), .rdata(o_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_row_reg  <= clr_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raddr_e_reg <= raddr_e_next;
        raddr_o_reg <= raddr_o_next;
        parity_reg  <= parity_next;
    end

    assign busy  = clr_busy_reg;
    assign word0 = parity_reg ? o_rdata : e_rdata;
    assign word1 = parity_reg ? e_rdata : o_rdata;

endmodule
